FILE: design/cwm_pkg.sv
package cwm_pkg;

  localparam int FRAC      = 8;
  localparam int MAX_DIM   = 4096;
  localparam int SQ_STEPS  = 25;
  localparam int DIV_STEPS = 21;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FOCAL  = 2'd2,
    REG_SHIFT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [49:0] rad;
    logic [25:0] srem;
    logic [24:0] root;
    logic [44:0] numx;
    logic [44:0] numy;
    logic [24:0] remx;
    logic [24:0] remy;
    logic [20:0] qx;
    logic [20:0] qy;
    logic        negx;
    logic        negy;
    logic [11:0] half_h;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cell_t;

endpackage

FILE: design/cwm_sqrt_cell.sv
module cwm_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cwm_pkg::cell_t din,
  output logic           out_valid,
  output cwm_pkg::cell_t dout
);

  logic [27:0]    r4;
  logic [27:0]    trial;
  logic [27:0]    diff;
  cwm_pkg::cell_t dout_next;

  // one root bit per cell, two radicand bits brought down
  always_comb begin
    r4        = {din.srem, din.rad[49:48]};
    trial     = {1'b0, din.root, 2'b01};
    diff      = r4 - trial;
    dout_next = din;
    dout_next.rad = {din.rad[47:0], 2'b00};
    if (r4 >= trial) begin
      dout_next.srem = diff[25:0];
      dout_next.root = {din.root[23:0], 1'b1};
    end else begin
      dout_next.srem = r4[25:0];
      dout_next.root = {din.root[23:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: design/cwm_div_cell.sv
module cwm_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cwm_pkg::cell_t din,
  output logic           out_valid,
  output cwm_pkg::cell_t dout
);

  logic [25:0]    rx;
  logic [25:0]    ry;
  logic [25:0]    dv;
  logic [25:0]    dx;
  logic [25:0]    dy;
  cwm_pkg::cell_t dout_next;

  // one quotient bit per cell for both axes, divisor is the root
  always_comb begin
    dv        = {1'b0, din.root};
    rx        = {din.remx, din.numx[20]};
    ry        = {din.remy, din.numy[20]};
    dx        = rx - dv;
    dy        = ry - dv;
    dout_next = din;
    dout_next.numx = {din.numx[43:0], 1'b0};
    dout_next.numy = {din.numy[43:0], 1'b0};
    if (rx >= dv) begin
      dout_next.remx = dx[24:0];
      dout_next.qx   = {din.qx[19:0], 1'b1};
    end else begin
      dout_next.remx = rx[24:0];
      dout_next.qx   = {din.qx[19:0], 1'b0};
    end
    if (ry >= dv) begin
      dout_next.remy = dy[24:0];
      dout_next.qy   = {din.qy[19:0], 1'b1};
    end else begin
      dout_next.remy = ry[24:0];
      dout_next.qy   = {din.qy[19:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: design/cylindrical_warp_mapper_unit.sv
// throughput: one request per cycle; the whole pipe holds while a result waits
// the pipe is offset, product and radicand registers, a 25-cell square-root
// chain, a 21-cell divider chain and an output register
// reset: pipe emptied, registers return to 640 x 480, focal 800.0, shift 297.1
// synchronous active-high reset
module cylindrical_warp_mapper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_col,
  output logic [11:0] out_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int SQ = cwm_pkg::SQ_STEPS;
  localparam int DV = cwm_pkg::DIV_STEPS;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [23:0] focal_length;
  logic [19:0] x_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd640;
      image_height <= 13'd480;
      focal_length <= 24'd204800;
      x_shift      <= 20'd76063;
    end else if (cfg_we) begin
      unique case (cwm_pkg::reg_idx_t'(cfg_index))
        cwm_pkg::REG_WIDTH:  image_width  <= cfg_data[12:0];
        cwm_pkg::REG_HEIGHT: image_height <= cfg_data[12:0];
        cwm_pkg::REG_FOCAL:  focal_length <= cfg_data;
        cwm_pkg::REG_SHIFT:  x_shift      <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  // stage 0: centered offsets
  logic [11:0] half_w;
  logic [11:0] half_h;
  logic [13:0] a_s;
  logic [13:0] b_s;

  always_comb begin
    half_w = (image_width > 13'(cwm_pkg::MAX_DIM)) ? 12'(cwm_pkg::MAX_DIM / 2)
                                                     : image_width[12:1];
    half_h = (image_height > 13'(cwm_pkg::MAX_DIM)) ? 12'(cwm_pkg::MAX_DIM / 2)
                                                      : image_height[12:1];
    a_s = {2'b00, col} - {2'b00, half_w};
    b_s = {2'b00, row} - {2'b00, half_h};
  end

  logic        v0;
  logic [12:0] abs_a0;
  logic [12:0] abs_b0;
  logic        nega0;
  logic        negb0;
  logic [11:0] hh0;
  logic [7:0]  r0, g0, bl0;
  logic [13:0] neg_a;
  logic [13:0] neg_b;

  assign neg_a = -a_s;
  assign neg_b = -b_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_a0 <= a_s[13] ? neg_a[12:0] : a_s[12:0];
      abs_b0 <= b_s[13] ? neg_b[12:0] : b_s[12:0];
      nega0  <= a_s[13];
      negb0  <= b_s[13];
      hh0    <= half_h;
      r0     <= in_red;
      g0     <= in_green;
      bl0    <= in_blue;
    end
  end

  // stage 1: products
  logic [20:0] big_a;
  logic [20:0] big_b;
  assign big_a = {abs_a0, 8'd0};
  assign big_b = {abs_b0, 8'd0};

  logic        v1;
  logic [41:0] sq_a1;
  logic [47:0] sq_f1;
  logic [44:0] nx1;
  logic [44:0] ny1;
  logic        nega1, negb1;
  logic [11:0] hh1;
  logic [7:0]  r1, g1, bl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a1 <= big_a * big_a;
      sq_f1 <= focal_length * focal_length;
      nx1   <= focal_length * big_a;
      ny1   <= focal_length * big_b;
      nega1 <= nega0;
      negb1 <= negb0;
      hh1   <= hh0;
      r1    <= r0;
      g1    <= g0;
      bl1   <= bl0;
    end
  end

  // stage 2: radicand, load into the root chain
  cwm_pkg::cell_t s2_next;
  cwm_pkg::cell_t s2;
  logic           v2;

  always_comb begin
    s2_next        = '0;
    s2_next.rad    = {1'b0, {7'd0, sq_a1} + {1'b0, sq_f1}};
    s2_next.numx   = nx1;
    s2_next.numy   = ny1;
    s2_next.negx   = nega1;
    s2_next.negy   = negb1;
    s2_next.half_h = hh1;
    s2_next.red    = r1;
    s2_next.green  = g1;
    s2_next.blue   = bl1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

  cwm_pkg::cell_t sq_d [SQ+1];
  logic           sq_v [SQ+1];
  assign sq_d[0] = s2;
  assign sq_v[0] = v2;

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    cwm_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_v[i]),
      .din       (sq_d[i]),
      .out_valid (sq_v[i+1]),
      .dout      (sq_d[i+1])
    );
  end

  // quotient fits 21 bits, so the top numerator bits start as remainder
  cwm_pkg::cell_t dv_in;
  cwm_pkg::cell_t dv_d [DV+1];
  logic           dv_v [DV+1];

  always_comb begin
    dv_in      = sq_d[SQ];
    dv_in.remx = {1'b0, sq_d[SQ].numx[44:21]};
    dv_in.remy = {1'b0, sq_d[SQ].numy[44:21]};
    dv_in.qx   = '0;
    dv_in.qy   = '0;
  end
  assign dv_d[0] = dv_in;
  assign dv_v[0] = sq_v[SQ];

  for (genvar i = 0; i < DV; i++) begin : g_div
    cwm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_v[i]),
      .din       (dv_d[i]),
      .out_valid (dv_v[i+1]),
      .dout      (dv_d[i+1])
    );
  end

  // final: sign, offset, saturate
  cwm_pkg::cell_t fin;
  logic [22:0]    xv;
  logic [22:0]    yv;
  logic [20:0]    qx;
  logic [20:0]    qy;
  logic [11:0]    col_next;
  logic [11:0]    row_next;

  always_comb begin
    fin = dv_d[DV];
    qx  = (fin.root == '0) ? '0 : fin.qx;
    qy  = (fin.root == '0) ? '0 : fin.qy;
    xv  = (fin.negx ? -{2'b00, qx} : {2'b00, qx}) + {3'b000, x_shift};
    yv  = (fin.negy ? -{2'b00, qy} : {2'b00, qy}) + {3'b000, fin.half_h, 8'd0};
    if (xv[22]) begin
      col_next = '0;
    end else if (xv[21:20] != 2'b00) begin
      col_next = 12'(cwm_pkg::MAX_DIM - 1);
    end else begin
      col_next = xv[19:8];
    end
    if (yv[22]) begin
      row_next = '0;
    end else if (yv[21:20] != 2'b00) begin
      row_next = 12'(cwm_pkg::MAX_DIM - 1);
    end else begin
      row_next = yv[19:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[DV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_col   <= col_next;
      out_row   <= row_next;
      out_red   <= fin.red;
      out_green <= fin.green;
      out_blue  <= fin.blue;
    end
  end

endmodule
